/* rtl/ils_pkg.sv */
// Shared types and constants for the indexed list store.
// Holds the opcode and status codes and the controller/datapath signal groups.
// No dependencies.
package ils_pkg;

    typedef logic signed [31:0] t_word;

    localparam logic [2:0] OP_GET  = 3'd0;
    localparam logic [2:0] OP_HEAD = 3'd1;
    localparam logic [2:0] OP_TAIL = 3'd2;
    localparam logic [2:0] OP_AT   = 3'd3;
    localparam logic [2:0] OP_DEL  = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADIDX = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic setup;
        logic rd;
        logic wr;
        logic fin;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic work_ok;
        logic more;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ils_req_if.sv */
// Request channel of the indexed list store: valid/ready plus the operation.
// Uses the word type from ils_pkg.
interface ils_req_if;
    logic          valid;
    logic          ready;
    logic [2:0]    opcode;
    logic [6:0]    position;
    ils_pkg::t_word value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface

/* rtl/ils_rsp_if.sv */
// Response channel of the indexed list store: valid/ready plus the result.
// Uses the word type from ils_pkg.
interface ils_rsp_if;
    logic          valid;
    logic          ready;
    ils_pkg::t_word read_value;
    logic [1:0]    status;
    logic [6:0]    count;

    modport source (output valid, read_value, status, count, input ready);
    modport sink   (input valid, read_value, status, count, output ready);
endinterface

/* rtl/ils_ctrl.sv */
// Controller state machine of the indexed list store.
// Depends on ils_pkg for the command and status groups.
module ils_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ils_pkg::t_stat i_stat,
    output ils_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_STEP   = 5'b00100,
        S_WR     = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_state = i_stat.work_ok ? S_STEP : S_FIN;
            end
            S_STEP: begin
                // Move one element per S_STEP/S_WR pass until no element is left to move.
                if (i_stat.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WR;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_FIN;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_STEP;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ils_dpath.sv */
// Datapath of the indexed list store: element memory, count, shift pointer
// and the result register. Depends on ils_pkg and the two channel interfaces.
module ils_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ils_pkg::t_cmd  i_cmd,
    output ils_pkg::t_stat o_stat,
    ils_req_if.sink        i_req,
    ils_rsp_if.source      o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > 7) ? CW : 7;

    logic [2:0]     r_op;
    logic [6:0]     r_pos;
    ils_pkg::t_word r_val;
    logic [CW-1:0]  r_occ;
    logic [CW-1:0]  r_ptr;
    logic [CW-1:0]  r_tgt;
    logic           r_is_ins;
    logic [1:0]     r_status;
    ils_pkg::t_word r_rdata;
    ils_pkg::t_word mem [CAPACITY];

    logic           r_rsp_valid;
    ils_pkg::t_word r_rsp_value;
    logic [1:0]     r_rsp_status;
    logic [6:0]     r_rsp_count;

    logic [W-1:0]   pos_w;
    logic [W-1:0]   occ_w;
    logic           pos_lt;
    logic           pos_gt;
    logic           full;
    logic           is_ins_op;
    logic           del_ok;
    logic [1:0]     status;
    logic [CW-1:0]  tgt;
    logic [CW-1:0]  ptr_dn;
    logic [CW-1:0]  ptr_up;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           capture;

    assign capture     = i_cmd.in_ready && i_req.valid;
    assign i_req.ready = i_cmd.in_ready;

    assign pos_w  = W'(r_pos);
    assign occ_w  = W'(r_occ);
    assign pos_lt = pos_w < occ_w;
    assign pos_gt = pos_w > occ_w;
    assign full   = occ_w == W'(CAPACITY);
    assign ptr_dn = r_ptr - CW'(1);
    assign ptr_up = r_ptr + CW'(1);

    always_comb begin
        is_ins_op = 1'b0;
        del_ok    = 1'b0;
        status    = ils_pkg::ST_DONE;
        tgt       = '0;
        case (r_op)
            ils_pkg::OP_GET: begin
                status = pos_lt ? ils_pkg::ST_DONE : ils_pkg::ST_BADIDX;
            end
            ils_pkg::OP_HEAD: begin
                is_ins_op = 1'b1;
                status    = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
            end
            ils_pkg::OP_TAIL: begin
                is_ins_op = 1'b1;
                tgt       = r_occ;
                status    = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
            end
            ils_pkg::OP_AT: begin
                // The index check comes before the full check.
                is_ins_op = 1'b1;
                tgt       = pos_w[CW-1:0];
                if (pos_gt) begin
                    status = ils_pkg::ST_BADIDX;
                end else begin
                    status = full ? ils_pkg::ST_FULL : ils_pkg::ST_DONE;
                end
            end
            ils_pkg::OP_DEL: begin
                del_ok = pos_lt;
                status = pos_lt ? ils_pkg::ST_DONE : ils_pkg::ST_BADIDX;
            end
            default: begin
                status = ils_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        o_stat.in_valid = i_req.valid;
        o_stat.work_ok  = (is_ins_op && (status == ils_pkg::ST_DONE)) || del_ok;
        if (r_is_ins) begin
            o_stat.more = r_ptr > r_tgt;
        end else begin
            o_stat.more = ({1'b0, r_ptr} + (CW+1)'(1)) < {1'b0, r_occ};
        end
        o_stat.out_free = !r_rsp_valid || o_rsp.ready;
    end

    // Inserts pull each element up from the slot below; deletes pull it down from above.
    always_comb begin
        rd_en = i_cmd.setup || i_cmd.rd;
        if (i_cmd.setup) begin
            rd_addr = pos_w[AW-1:0];
        end else if (r_is_ins) begin
            rd_addr = ptr_dn[AW-1:0];
        end else begin
            rd_addr = ptr_up[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_ptr[AW-1:0]] <= r_rdata;
        end else if (i_cmd.fin && r_is_ins) begin
            mem[r_ptr[AW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_op  <= i_req.opcode;
            r_pos <= i_req.position;
            r_val <= i_req.value;
        end
        if (i_cmd.setup) begin
            r_is_ins <= is_ins_op;
            r_status <= status;
            r_tgt    <= tgt;
            r_ptr    <= is_ins_op ? r_occ : pos_w[CW-1:0];
        end else if (i_cmd.wr) begin
            r_ptr <= r_is_ins ? ptr_dn : ptr_up;
        end
        if (i_cmd.out_load) begin
            if (r_op == ils_pkg::OP_GET) begin
                r_rsp_value <= (r_status == ils_pkg::ST_DONE) ? r_rdata : '1;
            end else begin
                r_rsp_value <= '0;
            end
            r_rsp_status <= r_status;
            r_rsp_count  <= occ_w[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_occ <= r_is_ins ? (r_occ + CW'(1)) : (r_occ - CW'(1));
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_rsp_value;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.count      = r_rsp_count;

endmodule

/* rtl/indexed_list_store.sv */
// Top level of the indexed list store: controller, datapath and checks.
// Depends on ils_pkg, ils_req_if, ils_rsp_if, ils_ctrl and ils_dpath.
//
// Ordered list of up to CAPACITY signed 32-bit values in a single-port
// memory, with get, insert at head, insert at tail, insert before an index
// and delete at an index. One request is worked at a time. An insert or
// delete moves each element across the memory through one read and one
// write, and a rejected request moves none. A new request is taken while
// the previous result still waits in the output register. The count field
// carries the low 7 bits of the element count.
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ils_req_if.sink   i_req,
    ils_rsp_if.source o_rsp
);

    localparam logic [6:0] CapLow = 7'(CAPACITY);

    ils_pkg::t_cmd  cmd;
    ils_pkg::t_stat stat;

    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ils_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    // A full response can only come from a list that holds CAPACITY elements.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ils_pkg::ST_FULL) |-> o_rsp.count == CapLow)
        else $error("full status with count below capacity");

    a_full_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ils_pkg::ST_FULL) |-> o_rsp.read_value == '0)
        else $error("dropped insert returned a nonzero value");

    // Requests are worked one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    a_shift_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |=> cmd.wr)
        else $error("shift read not followed by its write");

endmodule
